FILE: src/kb64_pkg.sv
`timescale 1ns / 1ps
package kb64_pkg;

   localparam int CHAR_CODES  = 128;
   localparam int CHAR_BITS   = $clog2(CHAR_CODES);
   localparam int ALPHA_SIZE  = 64;
   localparam int INDEX_BITS  = $clog2(ALPHA_SIZE);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ALPHA_SIZE*8-1:0] DEFAULT_KEY =
      "PaAwO65goUf7IK2vi9}xq8cFTEXLCDY1Hd3tV0ryzjbpN{BlnSs4mGRkQWMZJeuh";

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ENC   = 2'd0;
   localparam kind_type KIND_DEC   = 2'd1;
   localparam kind_type KIND_ALPHA = 2'd2;

   typedef struct packed {
      kind_type                kind;
      logic                    last;
      logic [7:0]              data;
      logic [INDEX_BITS-1:0]   index;
      logic                    flag;
   } queue_word_type;

   typedef struct packed {
      logic                    clear;
      logic                    we;
      logic [CHAR_BITS-1:0]    addr;
      logic [INDEX_BITS-1:0]   idx;
      logic                    done;
   } map_write_type;

   function automatic logic [6:0] default_char(input logic [INDEX_BITS-1:0] k);
      logic [7:0] c;
      c = DEFAULT_KEY[(ALPHA_SIZE - 1 - int'(k)) * 8 +: 8];
      return c[6:0];
   endfunction

endpackage

FILE: src/keyed_base64_codec.sv
`timescale 1ns / 1ps
// A word goes from the front's s1 register through the queue to the back; its outputs pass the
// emit and p registers into the rsp registers. The front takes one word per cycle while
// req_stall is low; the back pops the queue only when no group is issuing or as its last output
// issues (a group is 3 bytes encoded or 4 characters decoded). An accepted alphabet write holds
// req_stall high until the inverse map is rebuilt, a rejected one until the back pops it. Reset
// (synchronous, active high) restores the default alphabet, rebuilding the map under req_stall.
module keyed_base64_codec
   import kb64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_entry_index,
   input  logic [15:0] req_in_value,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_value,
   output logic        rsp_out_last,
   output logic        rsp_hit_invalid,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   map_write_type  map_wr;
   queue_word_type push_word;
   queue_word_type pop_word;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;

   kb64_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_in_value     (req_in_value),
      .req_in_last      (req_in_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .map_wr           (map_wr),
      .push             (push),
      .push_word        (push_word),
      .queue_full       (queue_full)
   );

   kb64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (queue_empty)
   );

   kb64_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .q_word           (pop_word),
      .q_empty          (queue_empty),
      .pop              (pop),
      .map_wr           (map_wr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_last     (rsp_out_last),
      .rsp_hit_invalid  (rsp_hit_invalid)
   );

endmodule

FILE: src/kb64_queue.sv
`timescale 1ns / 1ps
module kb64_queue
   import kb64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_word_type push_word,
   output logic           full,
   input  logic           pop,
   output queue_word_type pop_word,
   output logic           empty
);

   queue_word_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = entry_ff[rptr_ff];

   function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wptr_in  = (push && !full) ? bump(wptr_ff) : wptr_ff;
      rptr_in  = (pop && !empty) ? bump(rptr_ff) : rptr_ff;
      count_in = count_ff;
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wptr_ff] <= push_word;
      end
   end

endmodule

FILE: src/kb64_front.sv
`timescale 1ns / 1ps
module kb64_front
   import kb64_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [5:0]            req_entry_index,
   input  logic [15:0]           req_in_value,
   input  logic                  req_in_last,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   input  map_write_type         map_wr,
   output logic                  push,
   output queue_word_type        push_word,
   input  logic                  queue_full
);

   logic                  mode_ff;
   logic                  blocked_ff, blocked_in;
   logic                  s1_valid_ff, s1_valid_in;
   kind_type              s1_kind_ff;
   logic                  s1_last_ff;
   logic [7:0]            s1_data_ff;
   logic [INDEX_BITS-1:0] s1_index_ff;
   logic                  s1_range_ff;
   logic [INDEX_BITS-1:0] inv_mem [CHAR_CODES];
   logic [CHAR_CODES-1:0] inv_valid_ff;
   logic [INDEX_BITS-1:0] inv_q_ff;
   logic                  inv_v_ff;
   logic                  accept;
   logic [CHAR_BITS-1:0]  rd_addr;

   assign push      = s1_valid_ff && !queue_full;
   assign req_stall = blocked_ff || (s1_valid_ff && !push);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = req_in_value[CHAR_BITS-1:0];

   always_comb begin
      push_word.kind = s1_kind_ff;
      push_word.last = s1_last_ff;
      push_word.data = s1_data_ff;
      if (s1_kind_ff == KIND_DEC) begin
         push_word.index = inv_q_ff;
         push_word.flag  = s1_range_ff && inv_v_ff;
      end else begin
         push_word.index = s1_index_ff;
         push_word.flag  = s1_range_ff;
      end
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);
      blocked_in  = blocked_ff;
      if (accept && req_opcode) begin
         blocked_in = 1'b1;
      end else if (map_wr.done) begin
         blocked_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         blocked_ff   <= 1'b1;
         s1_valid_ff  <= 1'b0;
         inv_valid_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         blocked_ff  <= blocked_in;
         s1_valid_ff <= s1_valid_in;
         if (map_wr.clear) begin
            inv_valid_ff <= '0;
         end else if (map_wr.we) begin
            inv_valid_ff[map_wr.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (map_wr.we) begin
         inv_mem[map_wr.addr] <= map_wr.idx;
      end
      if (accept) begin
         inv_q_ff    <= inv_mem[rd_addr];
         inv_v_ff    <= inv_valid_ff[rd_addr];
         s1_kind_ff  <= req_opcode ? KIND_ALPHA : (mode_ff ? KIND_DEC : KIND_ENC);
         s1_last_ff  <= req_in_last;
         s1_data_ff  <= req_in_value[7:0];
         s1_index_ff <= req_entry_index;
         s1_range_ff <= (req_in_value < 16'(CHAR_CODES));
      end
   end

endmodule

FILE: src/kb64_back.sv
`timescale 1ns / 1ps
module kb64_back
   import kb64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  queue_word_type q_word,
   input  logic           q_empty,
   output logic           pop,
   output map_write_type  map_wr,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_value,
   output logic           rsp_out_last,
   output logic           rsp_hit_invalid
);

   logic [23:0]           acc_ff, acc_in;
   logic [1:0]            gcount_ff, gcount_in;
   logic                  stopped_ff, stopped_in;
   logic [23:0]           em_acc_ff, em_acc_in;
   logic [2:0]            em_cnt_ff, em_cnt_in;
   logic [1:0]            em_k_ff, em_k_in;
   logic                  em_enc_ff, em_enc_in;
   logic                  em_last_ff, em_last_in;
   logic                  em_inval_ff, em_inval_in;
   logic                  p_valid_ff;
   logic                  p_enc_ff;
   logic [7:0]            p_byte_ff;
   logic                  p_last_ff;
   logic                  p_inval_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_value_ff;
   logic                  rsp_last_ff;
   logic                  rsp_inval_ff;
   logic                  rb_active_ff, rb_active_in;
   logic [INDEX_BITS-1:0] rb_k_ff, rb_k_in;
   logic                  rd_pend_ff;
   logic [INDEX_BITS-1:0] rd_k_ff;
   logic [6:0]            alpha_mem [ALPHA_SIZE];
   logic [ALPHA_SIZE-1:0] alpha_valid_ff;
   logic [6:0]            mem_q_ff;
   logic [6:0]            def_q_ff;
   logic                  aval_q_ff;
   logic [6:0]            alpha_char;
   logic                  p_move, issue_ok, issue, rb_go;
   logic                  alpha_we, alpha_re, alpha_skip;
   logic [INDEX_BITS-1:0] alpha_raddr;
   logic [5:0]            slice;
   logic [7:0]            byte_sel;
   logic [23:0]           enc_acc, dec_acc;
   logic [1:0]            g_next;
   logic [2:0]            flush_cnt;

   assign alpha_char      = aval_q_ff ? mem_q_ff : def_q_ff;
   assign p_move          = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue_ok        = !p_valid_ff || p_move;
   assign issue           = (em_cnt_ff != 3'd0) && issue_ok;
   assign rb_go           = rb_active_ff && !p_valid_ff;
   assign pop             = !q_empty && !rb_active_ff && !rd_pend_ff &&
                            ((em_cnt_ff == 3'd0) || ((em_cnt_ff == 3'd1) && issue_ok));
   assign alpha_we        = pop && (q_word.kind == KIND_ALPHA) && (gcount_ff == 2'd0) &&
                            !stopped_ff && q_word.flag;
   assign alpha_skip      = pop && (q_word.kind == KIND_ALPHA) && !alpha_we;
   assign alpha_re        = rb_go || (issue && em_enc_ff);
   assign alpha_raddr     = rb_go ? rb_k_ff : slice;

   assign map_wr.clear    = alpha_we;
   assign map_wr.we       = rd_pend_ff;
   assign map_wr.addr     = CHAR_BITS'(alpha_char);
   assign map_wr.idx      = rd_k_ff;
   assign map_wr.done     = (rd_pend_ff && (rd_k_ff == INDEX_BITS'(ALPHA_SIZE - 1))) ||
                            alpha_skip;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_last    = rsp_last_ff;
   assign rsp_hit_invalid = rsp_inval_ff;

   always_comb begin
      case (em_k_ff)
         2'd0:    slice = em_acc_ff[5:0];
         2'd1:    slice = em_acc_ff[11:6];
         2'd2:    slice = em_acc_ff[17:12];
         default: slice = em_acc_ff[23:18];
      endcase
      case (em_k_ff)
         2'd0:    byte_sel = em_acc_ff[7:0];
         2'd1:    byte_sel = em_acc_ff[15:8];
         2'd2:    byte_sel = em_acc_ff[23:16];
         default: byte_sel = 8'd0;
      endcase
      case (gcount_ff)
         2'd0:    enc_acc = acc_ff | {16'd0, q_word.data};
         2'd1:    enc_acc = acc_ff | {8'd0, q_word.data, 8'd0};
         2'd2:    enc_acc = acc_ff | {q_word.data, 16'd0};
         default: enc_acc = acc_ff;
      endcase
      case (gcount_ff)
         2'd0:    dec_acc = acc_ff | {18'd0, q_word.index};
         2'd1:    dec_acc = acc_ff | {12'd0, q_word.index, 6'd0};
         2'd2:    dec_acc = acc_ff | {6'd0, q_word.index, 12'd0};
         default: dec_acc = acc_ff | {q_word.index, 18'd0};
      endcase
      g_next    = gcount_ff + 2'd1;
      flush_cnt = (gcount_ff >= 2'd2) ? {1'b0, gcount_ff} - 3'd1 : 3'd0;
   end

   always_comb begin
      acc_in       = acc_ff;
      gcount_in    = gcount_ff;
      stopped_in   = stopped_ff;
      em_acc_in    = em_acc_ff;
      em_cnt_in    = issue ? em_cnt_ff - 3'd1 : em_cnt_ff;
      em_k_in      = issue ? em_k_ff + 2'd1 : em_k_ff;
      em_enc_in    = em_enc_ff;
      em_last_in   = em_last_ff;
      em_inval_in  = em_inval_ff;
      rb_active_in = rb_active_ff;
      rb_k_in      = rb_k_ff;
      if (rb_go) begin
         if (rb_k_ff == INDEX_BITS'(ALPHA_SIZE - 1)) begin
            rb_active_in = 1'b0;
         end else begin
            rb_k_in = rb_k_ff + 1'b1;
         end
      end
      if (pop) begin
         em_k_in     = 2'd0;
         em_cnt_in   = 3'd0;
         em_last_in  = q_word.last;
         em_inval_in = 1'b0;
         case (q_word.kind)
            KIND_ENC: begin
               em_enc_in = 1'b1;
               em_acc_in = enc_acc;
               if (gcount_ff == 2'd2) begin
                  em_cnt_in = 3'd4;
               end else if (q_word.last) begin
                  em_cnt_in = {1'b0, gcount_ff} + 3'd2;
               end
               if ((gcount_ff == 2'd2) || q_word.last) begin
                  acc_in    = 24'd0;
                  gcount_in = 2'd0;
               end else begin
                  acc_in    = enc_acc;
                  gcount_in = g_next;
               end
            end
            KIND_DEC: begin
               em_enc_in = 1'b0;
               if (stopped_ff) begin
                  if (q_word.last) begin
                     stopped_in = 1'b0;
                  end
               end else if (!q_word.flag) begin
                  em_acc_in   = acc_ff;
                  em_cnt_in   = flush_cnt;
                  em_last_in  = 1'b1;
                  em_inval_in = 1'b1;
                  acc_in      = 24'd0;
                  gcount_in   = 2'd0;
                  stopped_in  = !q_word.last;
               end else if ((gcount_ff == 2'd3) || q_word.last) begin
                  em_acc_in  = dec_acc;
                  em_cnt_in  = (gcount_ff == 2'd3) ? 3'd3 : {1'b0, gcount_ff};
                  em_last_in = (gcount_ff == 2'd3) ? q_word.last : 1'b1;
                  acc_in     = 24'd0;
                  gcount_in  = 2'd0;
               end else begin
                  acc_in    = dec_acc;
                  gcount_in = g_next;
               end
            end
            default: begin
               if (alpha_we) begin
                  rb_active_in = 1'b1;
                  rb_k_in      = '0;
               end
            end
         endcase
      end
      if (csr_write_enable) begin
         acc_in     = 24'd0;
         gcount_in  = 2'd0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= 24'd0;
         gcount_ff      <= 2'd0;
         stopped_ff     <= 1'b0;
         em_cnt_ff      <= 3'd0;
         em_k_ff        <= 2'd0;
         p_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rb_active_ff   <= 1'b1;
         rb_k_ff        <= '0;
         rd_pend_ff     <= 1'b0;
         alpha_valid_ff <= '0;
      end else begin
         acc_ff       <= acc_in;
         gcount_ff    <= gcount_in;
         stopped_ff   <= stopped_in;
         em_cnt_ff    <= em_cnt_in;
         em_k_ff      <= em_k_in;
         rb_active_ff <= rb_active_in;
         rb_k_ff      <= rb_k_in;
         rd_pend_ff   <= rb_go;
         if (issue) begin
            p_valid_ff <= 1'b1;
         end else if (p_move) begin
            p_valid_ff <= 1'b0;
         end
         if (p_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (alpha_we) begin
            alpha_valid_ff[q_word.index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      em_acc_ff   <= em_acc_in;
      em_enc_ff   <= em_enc_in;
      em_last_ff  <= em_last_in;
      em_inval_ff <= em_inval_in;
      if (rb_go) begin
         rd_k_ff <= rb_k_ff;
      end
      if (alpha_we) begin
         alpha_mem[q_word.index] <= q_word.data[6:0];
      end
      if (alpha_re) begin
         mem_q_ff  <= alpha_mem[alpha_raddr];
         def_q_ff  <= default_char(alpha_raddr);
         aval_q_ff <= alpha_valid_ff[alpha_raddr];
      end
      if (issue) begin
         p_enc_ff   <= em_enc_ff;
         p_byte_ff  <= byte_sel;
         p_last_ff  <= em_last_ff && (em_cnt_ff == 3'd1);
         p_inval_ff <= em_inval_ff;
      end
      if (p_move) begin
         rsp_value_ff <= p_enc_ff ? {1'b0, alpha_char} : p_byte_ff;
         rsp_last_ff  <= p_last_ff;
         rsp_inval_ff <= p_inval_ff;
      end
   end

endmodule

FILE: bench/keyed_base64_codec_tb.sv
`timescale 1ns / 1ps
module keyed_base64_codec_tb;
   import kb64_pkg::*;

   localparam logic [64*8-1:0] BASE_KEY =
      "PaAwO65goUf7IK2vi9}xq8cFTEXLCDY1Hd3tV0ryzjbpN{BlnSs4mGRkQWMZJeuh";

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       flagged;
   } due_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [5:0]  req_entry_index = '0;
   logic [15:0] req_in_value = '0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_value;
   logic        rsp_out_last;
   logic        rsp_hit_invalid;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   bit          steady = 1'b0;
   int          errors_seen = 0;

   logic [6:0]  key_char [64];
   logic [6:0]  char_slot [CHAR_CODES];
   logic [23:0] pool;
   int          fill;
   bit          halted;
   logic        decode_mode;
   due_word_type due_words [$];

   keyed_base64_codec i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_in_value    (req_in_value),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_last    (rsp_out_last),
      .rsp_hit_invalid (rsp_hit_invalid),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 38);
   end

   function automatic void rebuild_slots();
      for (int c = 0; c < CHAR_CODES; c++) char_slot[c] = '0;
      for (int k = 0; k < 64; k++) begin
         if (key_char[k] < CHAR_CODES) char_slot[key_char[k]] = {1'b1, 6'(k)};
      end
   endfunction

   function automatic void drop_message();
      pool   = '0;
      fill   = 0;
      halted = 1'b0;
   endfunction

   function automatic void emit(input logic [7:0] v, input logic lst, input logic bad);
      due_word_type w;
      w.value   = v;
      w.last    = lst;
      w.flagged = bad;
      due_words.push_back(w);
   endfunction

   function automatic void flush_bytes(input int count, input logic bad);
      int nbytes;
      nbytes = (count >= 2) ? count - 1 : 0;
      for (int k = 0; k < nbytes; k++) emit(8'(pool >> (8 * k)), k + 1 == nbytes, bad);
      pool = '0;
      fill = 0;
   endfunction

   function automatic void codec_step(input logic op, input logic [5:0] idx,
                                      input logic [15:0] val, input logic lst);
      int         n;
      int         chars;
      logic [6:0] entry;
      if (op) begin
         if (fill == 0 && !halted && val < CHAR_CODES) begin
            key_char[idx] = val[6:0];
            rebuild_slots();
         end
         return;
      end
      n = fill + 1;
      if (!decode_mode) begin
         pool = pool | (24'(val[7:0]) << (8 * (n - 1)));
         if (n == 3) chars = 4;
         else if (lst) chars = n + 1;
         else begin
            fill = n;
            return;
         end
         for (int k = 0; k < chars; k++)
            emit({1'b0, key_char[6'(pool >> (6 * k))]}, lst && (k + 1 == chars), 1'b0);
         pool = '0;
         fill = 0;
         return;
      end
      if (halted) begin
         if (lst) halted = 1'b0;
         return;
      end
      entry = (val < CHAR_CODES) ? char_slot[val[6:0]] : 7'd0;
      if (!entry[6]) begin
         flush_bytes(fill, 1'b1);
         halted = !lst;
         return;
      end
      pool = pool | (24'(entry[5:0]) << (6 * (n - 1)));
      if (n == 4) begin
         for (int k = 0; k < 3; k++) emit(8'(pool >> (8 * k)), lst && (k == 2), 1'b0);
         pool = '0;
         fill = 0;
      end else if (lst) begin
         flush_bytes(n, 1'b0);
      end else begin
         fill = n;
      end
   endfunction

   always @(posedge clock) begin
      due_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            $error("unexpected word: out_value %0h", rsp_out_value);
            errors_seen++;
         end else begin
            want = due_words.pop_front();
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0h, actual %0h", want.value, rsp_out_value);
               errors_seen++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0b, actual %0b", want.last, rsp_out_last);
               errors_seen++;
            end
            if (rsp_hit_invalid !== want.flagged) begin
               $error("hit_invalid: expected %0b, actual %0b", want.flagged, rsp_hit_invalid);
               errors_seen++;
            end
         end
      end
   end

   task automatic put_word(input logic op, input logic [5:0] idx, input logic [15:0] val,
                           input logic lst);
      if (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_in_value    <= val;
      req_in_last     <= lst;
      do @(posedge clock); while (req_stall);
      codec_step(op, idx, val, lst);
   endtask

   task automatic send_data(input logic [15:0] val, input logic lst);
      put_word(1'b0, 6'($urandom), val, lst);
   endtask

   task automatic send_slot(input int k, input logic lst);
      send_data({9'd0, key_char[k]}, lst);
   endtask

   task automatic set_mode(input logic m);
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      decode_mode = m;
      drop_message();
   endtask

   task automatic test_encode_edges();
      set_mode(1'b0);
      send_data(16'h0000, 1'b0);
      send_data(16'h0000, 1'b0);
      send_data(16'h0000, 1'b1);
      send_data(16'h00FF, 1'b0);
      send_data(16'h00FF, 1'b0);
      send_data(16'hFFFF, 1'b1);
      send_data(16'hFFFF, 1'b1);
      send_data(16'h12AB, 1'b0);
      send_data(16'h34CD, 1'b1);
   endtask

   task automatic test_decode_edges();
      set_mode(1'b1);
      send_slot(0, 1'b0);
      send_slot(63, 1'b0);
      send_slot(5, 1'b0);
      send_slot(40, 1'b1);
      send_slot(1, 1'b0);
      send_slot(2, 1'b1);
      send_slot(7, 1'b1);
      send_slot(3, 1'b0);
      send_slot(4, 1'b0);
      send_data(16'hFFFF, 1'b0);
      put_word(1'b1, 6'd1, 16'h002B, 1'b0);
      send_slot(6, 1'b1);
      send_data(16'h002B, 1'b1);
   endtask

   task automatic test_alphabet_writes();
      logic [6:0] saved;
      put_word(1'b1, 6'd0, 16'h002B, 1'b0);
      send_data(16'h002B, 1'b0);
      send_slot(1, 1'b0);
      send_slot(2, 1'b1);
      put_word(1'b1, 6'd0, 16'h0050, 1'b1);
      send_slot(2, 1'b0);
      put_word(1'b1, 6'd5, 16'h0050, 1'b0);
      send_slot(3, 1'b1);
      put_word(1'b1, 6'd63, 16'h00C1, 1'b0);
      saved = key_char[10];
      put_word(1'b1, 6'd10, {9'd0, key_char[20]}, 1'b0);
      send_slot(20, 1'b0);
      send_slot(21, 1'b0);
      send_data({9'd0, saved}, 1'b1);
      put_word(1'b1, 6'd10, {9'd0, saved}, 1'b0);
   endtask

   task automatic test_random_traffic(input int words, input logic m, input bit calm);
      int          sent;
      int          pick;
      int          len;
      int          a;
      int          b;
      logic [6:0]  ca;
      logic [6:0]  cb;
      logic [15:0] v;
      set_mode(m);
      steady = calm;
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            a  = $urandom_range(63);
            b  = $urandom_range(63);
            ca = key_char[a];
            cb = key_char[b];
            put_word(1'b1, 6'(a), {9'd0, cb}, 1'($urandom));
            put_word(1'b1, 6'(b), {9'd0, ca}, 1'($urandom));
            sent += 2;
         end else if (pick < 16) begin
            put_word(1'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
            sent++;
         end else begin
            len = $urandom_range(1, 9);
            for (int k = 0; k < len; k++) begin
               if (m)
                  v = ($urandom_range(29) == 0) ? 16'($urandom)
                                                : {9'd0, key_char[$urandom_range(63)]};
               else
                  v = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(255));
               send_data(v, k == len - 1);
            end
            sent += len;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < 64; k++) key_char[k] = BASE_KEY[(63 - k) * 8 +: 7];
      rebuild_slots();
      drop_message();
      decode_mode = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_encode_edges();
      test_decode_edges();
      test_alphabet_writes();
      test_random_traffic(40, 1'b0, 1'b0);
      test_random_traffic(40, 1'b1, 1'b0);
      test_random_traffic(30, 1'b0, 1'b1);
      test_random_traffic(40, 1'b1, 1'b0);
      test_random_traffic(40, 1'b0, 1'b0);
      test_random_traffic(35, 1'b1, 1'b0);
      req_valid <= 1'b0;
      for (int c = 0; c < 20000 && due_words.size() != 0; c++) @(posedge clock);
      repeat (100) @(posedge clock);
      if (due_words.size() != 0) begin
         $error("words never delivered: %0d", due_words.size());
         errors_seen++;
      end
      if (errors_seen == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
